/* rtl/atst_pkg.sv */
// ----------------------------------------------------------------------------
// atst_pkg
// Types, constants and register codes shared by the step size tuner files.
// ----------------------------------------------------------------------------
package atst_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int CHI_W           = 32;
    localparam int TRIAL_W         = 16;
    localparam int STEP_W          = 32;
    localparam int INTERVAL_W      = 25;
    localparam int FACTOR_W        = 32;
    localparam int FACTOR_ONE_BITS = 30;
    localparam int PROD_W          = STEP_W + FACTOR_W;
    localparam int RUN_W           = 4;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    // shared shift-subtract unit
    localparam int SRC_W   = FACTOR_W + FACTOR_ONE_BITS;
    localparam int REM_W   = FACTOR_W + 3;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(SRC_W / 2);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(SRC_W);

    localparam logic [FACTOR_W-1:0]   FACTOR_RESET   = 32'd1127428915;
    localparam logic [FACTOR_W-1:0]   FACTOR_CAP     = 32'h8000_0000;
    localparam logic [FACTOR_W-1:0]   FACTOR_ONE     = 32'h4000_0000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 25'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 25'd16777216;

    localparam logic signed [RUN_W-1:0] RUN_HI       = 4'sd5;
    localparam logic signed [RUN_W-1:0] RUN_LO       = -4'sd5;
    localparam logic signed [RUN_W-1:0] RUN_ONE      = 4'sd1;
    localparam logic signed [RUN_W-1:0] RUN_RESTART  = 4'sd4;

    // register index = paddr[2]
    localparam logic REG_STEP_LIMIT = 1'b0;
    localparam logic REG_START_STEP = 1'b1;

    typedef enum logic {
        ITER_ROOT,
        ITER_DIV
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ROOT_WAIT,
        ST_SQ_MUL,
        ST_SQ_FIN,
        ST_STEP_MUL,
        ST_STEP_FIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

endpackage

/* rtl/atst_if.sv */
// ----------------------------------------------------------------------------
// atst_in_if / atst_out_if
// Valid/ready channels for adjustment requests and adjustment results.
// ----------------------------------------------------------------------------
interface atst_in_if import atst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHI_W-1:0]   chi_sum;
    logic [TRIAL_W-1:0] trial_count;

    modport source (output valid, output chi_sum, output trial_count, input ready);
    modport sink   (input valid, input chi_sum, input trial_count, output ready);
endinterface

interface atst_out_if import atst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STEP_W-1:0]     new_step;
    logic [INTERVAL_W-1:0] new_interval;
    logic                  went_up;

    modport source (output valid, output new_step, output new_interval,
                    output went_up, input ready);
    modport sink   (input valid, input new_step, input new_interval,
                    input went_up, output ready);
endinterface

/* rtl/adaptive_step_size_tuner_core.sv */
// ----------------------------------------------------------------------------
// adaptive_step_size_tuner_core
// Adjusts a Q16.16 step size from the mean acceptance of each request.
// An up request at the limit holds the step; otherwise the factor is first
// squared at a full run, or replaced by its root on a reversal, and the step
// is then multiplied by it for an up move or divided by it for a down move.
// One request at a time: the next is taken in the cycle after its result loads,
// so the 31-step root and 62-step divide of the shared unit set the rate.
// Synchronous active-low reset restores the register and state reset values.
// ----------------------------------------------------------------------------
module adaptive_step_size_tuner_core import atst_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    atst_in_if.sink            i_req,
    atst_out_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CMP_W = (TRIAL_W + FRAC_BITS > CHI_W + 1) ?
                           (TRIAL_W + FRAC_BITS) : (CHI_W + 1);
    localparam logic [STEP_W-1:0] LIMIT_RESET = STEP_W'(16) << FRAC_BITS;
    localparam logic [STEP_W-1:0] START_RESET = STEP_W'(1) << FRAC_BITS;

    t_state                   r_state, n_state;
    logic [STEP_W-1:0]        r_limit;
    logic [STEP_W-1:0]        r_start;
    logic [STEP_W-1:0]        r_step;
    logic [FACTOR_W-1:0]      r_factor;
    logic signed [RUN_W-1:0]  r_run;
    logic [INTERVAL_W-1:0]    r_interval;
    logic                     r_up;
    logic [PROD_W-1:0]        r_prod;

    logic                     r_out_valid;
    logic [STEP_W-1:0]        r_out_step;
    logic [INTERVAL_W-1:0]    r_out_interval;
    logic                     r_out_up;

    logic                     w_cfg_wr;
    logic                     w_up;
    logic                     w_rev;
    logic                     w_sq;
    logic                     w_hold;
    logic signed [RUN_W-1:0]  w_run_next;
    logic [INTERVAL_W:0]      w_dbl;
    logic [FACTOR_W-1:0]      w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-FACTOR_ONE_BITS-1:0] w_scaled;
    logic                     w_in_ready;
    logic                     w_out_load;
    t_iter_ctl                w_iter_ctl;
    t_iter_stat               w_iter_stat;
    logic [FACTOR_W-1:0]      w_iter_res;

    // ---------------- configuration port ----------------
    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_START_STEP) ? r_start : r_limit;

    // ---------------- decisions ----------------
    assign w_up = (CMP_W'({i_req.chi_sum, 1'b0}) >
                   (CMP_W'(i_req.trial_count) << FRAC_BITS));

    always_comb begin
        w_hold = r_up && (r_step >= r_limit);
        w_rev  = r_up ? (r_run < 0) : (r_run > 0);
        w_sq   = r_up ? (r_run == RUN_HI) : (r_run == RUN_LO);
        if (r_up) begin
            w_run_next = w_rev ? RUN_ONE : (w_sq ? RUN_RESTART : r_run + RUN_ONE);
        end else begin
            w_run_next = w_rev ? -RUN_ONE : (w_sq ? -RUN_RESTART : r_run - RUN_ONE);
        end
        w_dbl = {r_interval, 1'b0};
    end

    assign w_mul_b  = (r_state == ST_SQ_MUL) ? r_factor : r_step;
    assign w_prod   = PROD_W'(r_factor) * PROD_W'(w_mul_b);
    assign w_scaled = r_prod[PROD_W-1:FACTOR_ONE_BITS];

    atst_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_iter_ctl),
        .i_src    ((r_state == ST_DIV_GO) ? r_step : r_factor),
        .i_div    (r_factor),
        .o_stat   (w_iter_stat),
        .o_result (w_iter_res)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_hold)      n_state = ST_DONE;
                else if (w_rev)  n_state = ST_ROOT_WAIT;
                else if (w_sq)   n_state = ST_SQ_MUL;
                else if (r_up)   n_state = ST_STEP_MUL;
                else             n_state = ST_DIV_GO;
            end
            ST_ROOT_WAIT: begin
                if (w_iter_stat.done) n_state = r_up ? ST_STEP_MUL : ST_DIV_GO;
            end
            ST_SQ_MUL:   n_state = ST_SQ_FIN;
            ST_SQ_FIN:   n_state = r_up ? ST_STEP_MUL : ST_DIV_GO;
            ST_STEP_MUL: n_state = ST_STEP_FIN;
            ST_STEP_FIN: n_state = ST_DONE;
            ST_DIV_GO: begin
                n_state = (r_factor == '0) ? ST_DONE : ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_iter_stat.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        w_in_ready       = 1'b0;
        w_out_load       = 1'b0;
        w_iter_ctl.start = 1'b0;
        w_iter_ctl.mode  = ITER_ROOT;
        unique case (r_state)
            ST_IDLE:   w_in_ready = 1'b1;
            ST_DECIDE: w_iter_ctl.start = !w_hold && w_rev;
            ST_DIV_GO: begin
                w_iter_ctl.start = (r_factor != '0);
                w_iter_ctl.mode  = ITER_DIV;
            end
            ST_DONE:   w_out_load = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    assign i_req.ready = w_in_ready;

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_start     <= START_RESET;
            r_step      <= START_RESET;
            r_factor    <= FACTOR_RESET;
            r_run       <= '0;
            r_interval  <= INTERVAL_RESET;
            r_up        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                if (paddr[2] == REG_START_STEP) begin
                    r_start <= pwdata;
                    r_step  <= pwdata;
                end else begin
                    r_limit <= pwdata;
                end
            end

            if (w_in_ready && i_req.valid) r_up <= w_up;

            unique case (r_state)
                ST_DECIDE: begin
                    if (!w_hold) begin
                        r_run <= w_run_next;
                        if (w_rev) begin
                            r_interval <= (w_dbl > (INTERVAL_W+1)'(INTERVAL_MAX)) ?
                                          INTERVAL_MAX : w_dbl[INTERVAL_W-1:0];
                        end
                    end
                end
                ST_ROOT_WAIT: begin
                    if (w_iter_stat.done) r_factor <= w_iter_res;
                end
                ST_SQ_FIN: begin
                    r_factor <= (w_scaled > $bits(w_scaled)'(FACTOR_CAP)) ?
                                FACTOR_CAP : w_scaled[FACTOR_W-1:0];
                end
                ST_STEP_FIN: begin
                    r_step <= (w_scaled > $bits(w_scaled)'(r_limit)) ?
                              r_limit : w_scaled[STEP_W-1:0];
                end
                ST_DIV_WAIT: begin
                    if (w_iter_stat.done) r_step <= w_iter_res;
                end
                default: ;
            endcase

            // result register: a new result may replace one taken this cycle
            if (w_out_load)       r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQ_MUL || r_state == ST_STEP_MUL) r_prod <= w_prod;
        if (w_out_load) begin
            r_out_step     <= r_step;
            r_out_interval <= r_interval;
            r_out_up       <= r_up;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.new_step     = r_out_step;
    assign o_rsp.new_interval = r_out_interval;
    assign o_rsp.went_up      = r_out_up;

    // ---------------- assertions ----------------
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run <= RUN_HI) && (r_run >= RUN_LO))
        else $error("run count out of range");

    a_factor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_factor >= FACTOR_ONE)
        else $error("adjust factor fell below one");

    a_interval_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_interval >= INTERVAL_RESET) && (r_interval <= INTERVAL_MAX))
        else $error("interval out of range");

    a_iter_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_iter_ctl.start |-> !w_iter_stat.busy)
        else $error("shared unit started while busy");

endmodule

/* rtl/atst_iter.sv */
// ----------------------------------------------------------------------------
// atst_iter
// Shared shift-subtract unit: one result bit per cycle. Root mode gives
// floor(sqrt(src * 2^30)), divide mode gives the low 32 bits of
// (src * 2^30) / div.
// ----------------------------------------------------------------------------
module atst_iter import atst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_iter_ctl           i_ctl,
    input  logic [FACTOR_W-1:0] i_src,
    input  logic [FACTOR_W-1:0] i_div,
    output t_iter_stat          o_stat,
    output logic [FACTOR_W-1:0] o_result
);

    logic [SRC_W-1:0]    r_src;
    logic [REM_W-1:0]    r_rem;
    logic [FACTOR_W-1:0] r_res;
    logic [FACTOR_W-1:0] r_div;
    logic [CNT_W-1:0]    r_cnt;
    t_iter_mode          r_mode;
    logic                r_busy;
    logic                r_done;

    logic [REM_W-1:0]    w_shift;
    logic [REM_W-1:0]    w_trial;
    logic [REM_W-1:0]    w_diff;
    logic                w_ge;

    always_comb begin
        if (r_mode == ITER_ROOT) begin
            // two radicand bits per step, trial = 4*root + 1
            w_shift = {r_rem[REM_W-3:0], r_src[SRC_W-1 -: 2]};
            w_trial = REM_W'({r_res, 2'b01});
        end else begin
            w_shift = {r_rem[REM_W-2:0], r_src[SRC_W-1]};
            w_trial = REM_W'(r_div);
        end
        w_ge   = (w_shift >= w_trial);
        w_diff = w_shift - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= ITER_ROOT;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctl.mode;
                r_cnt  <= (i_ctl.mode == ITER_ROOT) ? ROOT_STEPS : DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_src <= {i_src, FACTOR_ONE_BITS'(0)};
            r_rem <= '0;
            r_res <= '0;
            r_div <= i_div;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_shift;
            r_res <= {r_res[FACTOR_W-2:0], w_ge};
            r_src <= (r_mode == ITER_ROOT) ? (r_src << 2) : (r_src << 1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_res;

endmodule
